### rtl/core/rbh_pkg.sv
package rbh_pkg;

  // Number of coordinate axes and of the other axes beside each one.
  localparam int unsigned NumAxes = 3;
  localparam int unsigned OtherAxes = 2;

  // Field widths.
  localparam int unsigned CoordW = 32;
  localparam int unsigned DiffW  = CoordW + 1;
  localparam int unsigned ProdW  = 2 * DiffW;
  localparam int unsigned TolW   = 16;
  localparam int unsigned CmpW   = CoordW + 2;
  localparam int unsigned AddrW  = 5;
  localparam int unsigned DataW  = 32;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic signed [DiffW-1:0]  diff_t;
  typedef logic signed [ProdW-1:0]  prod_t;
  typedef logic        [TolW-1:0]   tol_t;
  typedef logic        [1:0]        axis_t;

  // Register map, one word per register.
  typedef enum logic [2:0] {
    RegXLow  = 3'd0,
    RegXHigh = 3'd1,
    RegYLow  = 3'd2,
    RegYHigh = 3'd3,
    RegZLow  = 3'd4,
    RegZHigh = 3'd5,
    RegTol   = 3'd6
  } reg_idx_e;

  // Box bounds and tolerance as seen by the datapath.
  typedef struct packed {
    coord_t [NumAxes-1:0] lo;
    coord_t [NumAxes-1:0] hi;
    tol_t                 tol;
  } cfg_t;

  // Differences and face qualifiers after the first compute stage.
  typedef struct packed {
    diff_t  [NumAxes-1:0] num;
    diff_t  [NumAxes-1:0] den;
    diff_t  [NumAxes-1:0] dlo;
    diff_t  [NumAxes-1:0] dhi;
    coord_t [NumAxes-1:0] dir;
    logic   [NumAxes-1:0] face_ok;
    logic                 in_box;
  } prep_t;

  // Cross products for each candidate face and each of its two other axes.
  typedef struct packed {
    prod_t [NumAxes-1:0][OtherAxes-1:0] rhs;
    prod_t [NumAxes-1:0][OtherAxes-1:0] lo_side;
    prod_t [NumAxes-1:0][OtherAxes-1:0] hi_side;
    logic  [NumAxes-1:0]                face_ok;
    logic                               in_box;
  } prod_res_t;

  // Sign extension of a coordinate by one bit.
  function automatic diff_t sext_diff(coord_t v);
    return diff_t'({v[CoordW-1], v});
  endfunction

  // Sign extension of a coordinate by two bits for tolerance compares.
  function automatic logic signed [CmpW-1:0] sext_cmp(coord_t v);
    return {{2{v[CoordW-1]}}, v};
  endfunction

  // The j-th axis other than axis a.
  function automatic axis_t other_axis(axis_t a, logic j);
    axis_t r;
    if (!j) begin
      r = (a == 2'd0) ? 2'd1 : 2'd0;
    end else begin
      r = (a == 2'd2) ? 2'd1 : 2'd2;
    end
    return r;
  endfunction

endpackage

### rtl/core/ray_box_hit_test.sv
// Ray against axis-aligned box hit test. One ray transfer is taken in every
// clock cycle (busy is tied low) and each ray gives exactly one hit_o result,
// shown with hit_valid_o for a single cycle once it has passed every stage;
// the receiver cannot stall, so results must be taken as they appear. The
// pipeline is input register, difference stage, a bank of eighteen 33 x 33
// bit signed products, and the compare stage. Box bounds and tolerance are
// written over the APB port and must only change while no ray is in flight.
module ray_box_hit_test (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // Ray command channel
  input  logic                       start,
  output logic                       busy,
  input  rbh_pkg::coord_t            start_x_i,
  input  rbh_pkg::coord_t            start_y_i,
  input  rbh_pkg::coord_t            start_z_i,
  input  rbh_pkg::coord_t            dir_x_i,
  input  rbh_pkg::coord_t            dir_y_i,
  input  rbh_pkg::coord_t            dir_z_i,
  // Result
  output logic                       hit_valid_o,
  output logic                       hit_o,
  // Configuration port
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [rbh_pkg::AddrW-1:0]  paddr,
  input  logic [rbh_pkg::DataW-1:0]  pwdata,
  output logic [rbh_pkg::DataW-1:0]  prdata,
  output logic                       pready
);
  import rbh_pkg::*;

  cfg_t                 cfg;
  coord_t [NumAxes-1:0] start_vec, dir_vec;
  logic                 in_valid;
  logic                 prep_valid, prod_valid;
  prep_t                prep;
  prod_res_t            prod;

  // The pipeline takes a ray every cycle.
  assign busy     = 1'b0;
  assign in_valid = start && !busy;

  assign start_vec = {start_z_i, start_y_i, start_x_i};
  assign dir_vec   = {dir_z_i, dir_y_i, dir_x_i};

  rbh_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  rbh_prep u_prep (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .start_i    (start_vec),
    .dir_i      (dir_vec),
    .cfg_i      (cfg),
    .valid_o    (prep_valid),
    .prep_o     (prep)
  );

  rbh_prod u_prod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (prep_valid),
    .prep_i  (prep),
    .valid_o (prod_valid),
    .prod_o  (prod)
  );

  rbh_decide u_decide (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (prod_valid),
    .prod_i      (prod),
    .hit_valid_o (hit_valid_o),
    .hit_o       (hit_o)
  );

endmodule

### rtl/core/rbh_cfg.sv
module rbh_cfg (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [rbh_pkg::AddrW-1:0]  paddr,
  input  logic [rbh_pkg::DataW-1:0]  pwdata,
  output logic [rbh_pkg::DataW-1:0]  prdata,
  output logic                       pready,
  output rbh_pkg::cfg_t              cfg_o
);
  import rbh_pkg::*;

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_e'(paddr[AddrW-1:2]);
  assign wr_en  = psel && penable && pwrite && pready;

  // Register write decode; addresses beyond the map are ignored.
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        RegXLow:  cfg_d.lo[0] = coord_t'(pwdata);
        RegXHigh: cfg_d.hi[0] = coord_t'(pwdata);
        RegYLow:  cfg_d.lo[1] = coord_t'(pwdata);
        RegYHigh: cfg_d.hi[1] = coord_t'(pwdata);
        RegZLow:  cfg_d.lo[2] = coord_t'(pwdata);
        RegZHigh: cfg_d.hi[2] = coord_t'(pwdata);
        RegTol:   cfg_d.tol   = pwdata[TolW-1:0];
        default:  cfg_d       = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.lo  <= '0;
      cfg_q.hi  <= '0;
      cfg_q.tol <= tol_t'(1);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Read mux.
  always_comb begin
    case (idx)
      RegXLow:  prdata = DataW'(cfg_q.lo[0]);
      RegXHigh: prdata = DataW'(cfg_q.hi[0]);
      RegYLow:  prdata = DataW'(cfg_q.lo[1]);
      RegYHigh: prdata = DataW'(cfg_q.hi[1]);
      RegZLow:  prdata = DataW'(cfg_q.lo[2]);
      RegZHigh: prdata = DataW'(cfg_q.hi[2]);
      RegTol:   prdata = {{(DataW-TolW){1'b0}}, cfg_q.tol};
      default:  prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

### rtl/core/rbh_prep.sv
module rbh_prep (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    in_valid_i,
  input  rbh_pkg::coord_t [rbh_pkg::NumAxes-1:0]  start_i,
  input  rbh_pkg::coord_t [rbh_pkg::NumAxes-1:0]  dir_i,
  input  rbh_pkg::cfg_t                           cfg_i,
  output logic                                    valid_o,
  output rbh_pkg::prep_t                          prep_o
);
  import rbh_pkg::*;

  logic                   in_valid_q;
  coord_t [NumAxes-1:0]   s_q, d_q;
  logic                   valid_q;
  prep_t                  prep_q, prep_d;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      valid_q    <= 1'b0;
    end else begin
      in_valid_q <= in_valid_i;
      valid_q    <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i) begin
      s_q <= start_i;
      d_q <= dir_i;
    end
    prep_q <= prep_d;
  end

  // Per axis: which face the ray can enter, its signed numerator and
  // non-negative denominator, and the offsets of the bounds from the start.
  always_comb begin
    logic signed [CmpW-1:0] s34, d34, lo34, hi34, tol34;
    logic                   dneg, dpos, out_a;
    prep_d        = '0;
    prep_d.in_box = 1'b1;
    for (int a = 0; a < NumAxes; a++) begin
      s34   = sext_cmp(s_q[a]);
      d34   = sext_cmp(d_q[a]);
      lo34  = sext_cmp(cfg_i.lo[a]);
      hi34  = sext_cmp(cfg_i.hi[a]);
      tol34 = {{(CmpW-TolW){1'b0}}, cfg_i.tol};
      dneg  = (d34 + tol34) < 0;
      dpos  = (d34 - tol34) > 0;
      prep_d.face_ok[a] = (dneg && (s34 > hi34)) || (dpos && (s34 < lo34));
      // A ray heading down enters through the high face, else the low face.
      if (d_q[a][CoordW-1]) begin
        prep_d.num[a] = sext_diff(s_q[a]) - sext_diff(cfg_i.hi[a]);
        prep_d.den[a] = diff_t'(0) - sext_diff(d_q[a]);
      end else begin
        prep_d.num[a] = sext_diff(cfg_i.lo[a]) - sext_diff(s_q[a]);
        prep_d.den[a] = sext_diff(d_q[a]);
      end
      prep_d.dlo[a] = sext_diff(cfg_i.lo[a]) - sext_diff(s_q[a]);
      prep_d.dhi[a] = sext_diff(cfg_i.hi[a]) - sext_diff(s_q[a]);
      prep_d.dir[a] = d_q[a];
      out_a = (s34 > (hi34 + tol34)) || (s34 < (lo34 - tol34));
      if (out_a) begin
        prep_d.in_box = 1'b0;
      end
    end
  end

  assign valid_o = valid_q;
  assign prep_o  = prep_q;

endmodule

### rtl/core/rbh_prod.sv
module rbh_prod (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  rbh_pkg::prep_t       prep_i,
  output logic                 valid_o,
  output rbh_pkg::prod_res_t   prod_o
);
  import rbh_pkg::*;

  logic      valid_q;
  prod_res_t prod_q, prod_d;

  // Cross products that replace the division for the crossing point:
  // num * dir[k] is compared against (bound[k] - start[k]) * den.
  always_comb begin
    axis_t k;
    prod_d         = '0;
    prod_d.face_ok = prep_i.face_ok;
    prod_d.in_box  = prep_i.in_box;
    for (int a = 0; a < NumAxes; a++) begin
      for (int j = 0; j < OtherAxes; j++) begin
        k = other_axis(axis_t'(a), j[0]);
        prod_d.rhs[a][j]     = $signed(prep_i.num[a]) * $signed(sext_diff(prep_i.dir[k]));
        prod_d.lo_side[a][j] = $signed(prep_i.dlo[k]) * $signed(prep_i.den[a]);
        prod_d.hi_side[a][j] = $signed(prep_i.dhi[k]) * $signed(prep_i.den[a]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  assign valid_o = valid_q;
  assign prod_o  = prod_q;

endmodule

### rtl/core/rbh_decide.sv
module rbh_decide (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  rbh_pkg::prod_res_t   prod_i,
  output logic                 hit_valid_o,
  output logic                 hit_o
);
  import rbh_pkg::*;

  logic hit_valid_q;
  logic hit_q, hit_d;

  // A hit is a start inside the box or a qualifying face crossed strictly inside both other axes.
  always_comb begin
    logic face_hit;
    hit_d = prod_i.in_box;
    for (int a = 0; a < NumAxes; a++) begin
      face_hit = prod_i.face_ok[a];
      for (int j = 0; j < OtherAxes; j++) begin
        if (!(($signed(prod_i.lo_side[a][j]) < $signed(prod_i.rhs[a][j])) &&
              ($signed(prod_i.rhs[a][j]) < $signed(prod_i.hi_side[a][j])))) begin
          face_hit = 1'b0;
        end
      end
      if (face_hit) begin
        hit_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_valid_q <= 1'b0;
    end else begin
      hit_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    hit_q <= hit_d;
  end

  assign hit_valid_o = hit_valid_q;
  assign hit_o       = hit_q;

endmodule
